/* rtl/circular_queue_with_traverse_top_macros.svh */
// Assertion macros used by the circular queue back end.
// No dependencies; included by the modules that carry assertions.
`ifndef CIRCULAR_QUEUE_WITH_TRAVERSE_TOP_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_TRAVERSE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CQT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CQT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cqt_pkg.sv */
// Types and codes shared by the circular queue front end, back end and top level.
// No dependencies.
package cqt_pkg;

    localparam int DATA_W = 32;

    // Operation codes carried on s_tuser; code 3 is unused and dropped.
    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DELETE   = 2'd1,
        KIND_TRAVERSE = 2'd2
    } kind_t;

    // Result status carried on m_tuser.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One queued command between front and back.
    typedef struct packed {
        kind_t              op;
        logic [DATA_W-1:0]  data;
    } cmd_t;

endpackage

/* rtl/cqt_front.sv */
// Front end: accepts input words, drops unused codes, buffers commands in a
// two-entry queue for the back end. Depends on cqt_pkg.
module cqt_front
    import cqt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    localparam int QDEPTH = 2;

    cmd_t       q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       is_cmd;
    logic       push;

    assign s_tready  = (cnt_reg != 2'(QDEPTH));
    assign is_cmd    = s_tuser inside {KIND_INSERT, KIND_DELETE, KIND_TRAVERSE};
    assign push      = s_tvalid && s_tready && is_cmd;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, cmd_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{op: kind_t'(s_tuser), data: s_tdata};
        end
    end

endmodule

/* rtl/cqt_back.sv */
// Back end: slot memory, head/tail/occupancy, traverse walker and result
// pipeline. Depends on cqt_pkg and the assertion macro header.
`include "circular_queue_with_traverse_top_macros.svh"

module cqt_back
    import cqt_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          trav_busy_reg, trav_busy_next;
    logic [AW-1:0] trav_ptr_reg, trav_ptr_next;
    logic [CW-1:0] trav_cnt_reg, trav_cnt_next;

    logic          p1_valid_reg, p1_valid_next;
    status_t       p1_status_reg, p1_status_next;
    logic          p1_last_reg, p1_last_next;
    logic          p1_mem_reg, p1_mem_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    logic          p1_move;
    logic          can_issue;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] rd_addr;

    assign p1_move   = !out_valid_reg || m_tready;
    assign can_issue = !p1_valid_reg || p1_move;
    assign rd_addr   = trav_busy_reg ? trav_ptr_reg : head_reg;

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        trav_busy_next = trav_busy_reg;
        trav_ptr_next  = trav_ptr_reg;
        trav_cnt_next  = trav_cnt_reg;
        p1_valid_next  = p1_valid_reg;
        p1_status_next = p1_status_reg;
        p1_last_next   = p1_last_reg;
        p1_mem_next    = p1_mem_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        cmd_pop        = 1'b0;

        if (can_issue) begin
            p1_valid_next = 1'b0;
        end

        if (cmd_valid && can_issue) begin
            p1_valid_next  = 1'b1;
            p1_status_next = ST_OK;
            p1_last_next   = 1'b1;
            p1_mem_next    = 1'b0;
            case (cmd.op)
                KIND_INSERT: begin
                    cmd_pop = 1'b1;
                    if (occ_reg == FULL_CNT) begin
                        p1_status_next = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        tail_next = wrap_inc(tail_reg);
                        occ_next  = occ_reg + 1'b1;
                    end
                end
                KIND_DELETE: begin
                    cmd_pop = 1'b1;
                    if (occ_reg == '0) begin
                        p1_status_next = ST_EMPTY;
                    end else begin
                        mem_re      = 1'b1;
                        p1_mem_next = 1'b1;
                        head_next   = wrap_inc(head_reg);
                        occ_next    = occ_reg - 1'b1;
                    end
                end
                KIND_TRAVERSE: begin
                    if (occ_reg == '0) begin
                        cmd_pop        = 1'b1;
                        p1_status_next = ST_EMPTY;
                    end else begin
                        mem_re      = 1'b1;
                        p1_mem_next = 1'b1;
                        if (trav_cnt_reg + 1'b1 == occ_reg) begin
                            // newest entry reached: retire the command
                            cmd_pop        = 1'b1;
                            trav_busy_next = 1'b0;
                            trav_cnt_next  = '0;
                        end else begin
                            p1_last_next   = 1'b0;
                            trav_busy_next = 1'b1;
                            trav_ptr_next  = wrap_inc(rd_addr);
                            trav_cnt_next  = trav_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    cmd_pop       = 1'b1;
                    p1_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            trav_busy_reg <= 1'b0;
            trav_cnt_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            trav_busy_reg <= trav_busy_next;
            trav_cnt_reg  <= trav_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            if (p1_move) begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        trav_ptr_reg  <= trav_ptr_next;
        p1_status_reg <= p1_status_next;
        p1_last_reg   <= p1_last_next;
        p1_mem_reg    <= p1_mem_next;
        if (p1_move && p1_valid_reg) begin
            out_data_reg   <= p1_mem_reg ? rd_data_reg : '0;
            out_status_reg <= p1_status_reg;
            out_last_reg   <= p1_last_reg;
        end
    end

    // slot storage, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= cmd.data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `CQT_ASSERT_NOW(a_occ_range, aclk, aresetn, 1'b1, occ_reg <= FULL_CNT, "occupancy above depth")
    `CQT_ASSERT_NOW(a_ptr_match, aclk, aresetn, (occ_reg == '0) || (occ_reg == FULL_CNT), head_reg == tail_reg, "head/tail disagree with occupancy")
    `CQT_ASSERT_NOW(a_trav_nonempty, aclk, aresetn, trav_busy_reg, (occ_reg != '0) && (trav_cnt_reg < occ_reg), "traverse walker out of range")
    `CQT_ASSERT_NEXT(a_pop_ends_trav, aclk, aresetn, cmd_pop, !trav_busy_reg, "traverse still busy after retire")

endmodule

/* rtl/circular_queue_with_traverse_top.sv */
// Top level of the circular queue with traverse: front end, command queue
// and back end. Depends on cqt_pkg, cqt_front and cqt_back.
//
// Usage:
//   Input channel (s_): one word per operation. s_tuser selects the operation
//   (insert, delete oldest, traverse); s_tdata is the value for insert. Code 3
//   is accepted and discarded without a result.
//   Result channel (m_): m_tuser is the status (ok, full, empty), m_tdata the
//   removed or stored value (zero otherwise), m_tlast marks the final result
//   of an operation. Traverse of N stored values gives N words, oldest first.
//   Result path: each input word passes the command queue, then the memory
//   read, then the output register before its first result appears.
//   Throughput: while the receiver does not stall, insert and delete run at one
//   word per cycle; a traverse emits one word per cycle and holds the back end
//   until every stored entry is walked, since the single read port of the slot memory is walked one entry at a time.
//   Reset (aresetn low, synchronous): queue empty, pointers at zero, both
//   channels idle. Slot contents are not cleared; no read touches them
//   before they are written.
//   Receiver stall: results hold in the output register; the back end and
//   then the two-entry command queue fill, after which s_tready drops.
module circular_queue_with_traverse_top
    import cqt_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]        s_tuser,   // [1:0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] data_out
    output logic [1:0]        m_tuser,   // [1:0] status
    output logic              m_tlast
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // accept and classify
    cqt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // execute against the slot memory
    cqt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for circular_queue_with_traverse_top: a mirror of the
// circular queue predicts every result word, which is checked against m_ in order.
// Depends on cqt_pkg and the RTL top level with its front end, back end and macro header.
`timescale 1ns / 100ps

module testbench;
    import cqt_pkg::*;

    localparam int          QDEPTH      = 16;
    localparam int unsigned RANDOM_OPS  = 415;
    localparam int unsigned CYCLE_LIMIT = 800_000;
    localparam int unsigned TAIL_WAIT   = 40;     // covers the result path plus a 16-word traverse
    localparam int unsigned SHOW_ERRORS = 10;

    // Operation code the block accepts and drops without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One result word as seen on the m_ channel.
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] value;
        logic              last;
    } qresult_t;

    // Mirror of the queue plus the list of result words still owed by the block.
    class queue_scoreboard;
        logic [DATA_W-1:0] slot_mem [QDEPTH];
        int unsigned       rd_ptr;
        int unsigned       wr_ptr;
        int unsigned       fill;
        qresult_t          owed_words [$];
        int unsigned       mismatches;
        int unsigned       words_checked;
        int unsigned       n_insert, n_full, n_delete, n_empty, n_traverse, n_dropped;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            fill   = 0;
        endfunction

        function void owe(status_t st, logic [DATA_W-1:0] value, logic last);
            qresult_t w;
            w.status = st;
            w.value  = value;
            w.last   = last;
            owed_words.push_back(w);
        endfunction

        // Apply one accepted operation to the mirror and queue up its results.
        function void note_op(logic [1:0] kind, logic [DATA_W-1:0] value);
            int unsigned idx;
            case (kind)
                KIND_INSERT: begin
                    n_insert++;
                    if (fill == QDEPTH) begin
                        n_full++;
                        owe(ST_FULL, '0, 1'b1);
                    end else begin
                        slot_mem[wr_ptr] = value;
                        wr_ptr = (wr_ptr + 1) % QDEPTH;
                        fill++;
                        owe(ST_OK, '0, 1'b1);
                    end
                end
                KIND_DELETE: begin
                    n_delete++;
                    if (fill == 0) begin
                        n_empty++;
                        owe(ST_EMPTY, '0, 1'b1);
                    end else begin
                        owe(ST_OK, slot_mem[rd_ptr], 1'b1);
                        rd_ptr = (rd_ptr + 1) % QDEPTH;
                        fill--;
                    end
                end
                KIND_TRAVERSE: begin
                    n_traverse++;
                    if (fill == 0) begin
                        owe(ST_EMPTY, '0, 1'b1);
                    end else begin
                        // oldest first, queue left as is
                        idx = rd_ptr;
                        for (int i = 0; i < fill; i++) begin
                            owe(ST_OK, slot_mem[idx], (i == fill - 1));
                            idx = (idx + 1) % QDEPTH;
                        end
                    end
                end
                default: n_dropped++;
            endcase
        endfunction

        function void check_word(logic [1:0] st, logic [DATA_W-1:0] value, logic last);
            qresult_t w;
            words_checked++;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_ERRORS)
                    $display("unexpected word: status %0d data %h last %b", st, value, last);
                return;
            end
            w = owed_words.pop_front();
            if (st !== w.status || value !== w.value || last !== w.last) begin
                mismatches++;
                if (mismatches <= SHOW_ERRORS) begin
                    $display("mismatch: expected status %0d data %h last %b",
                             w.status, w.value, w.last);
                    $display("          got      status %0d data %h last %b",
                             st, value, last);
                end
            end
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction
    endclass

    // Clock, reset and DUT ports; every input starts at a known value.
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [31:0] data_in
    logic [1:0]        s_tuser  = '0;   // [1:0] kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [31:0] data_out
    logic [1:0]        m_tuser;         // [1:0] status
    logic              m_tlast;

    queue_scoreboard board;
    bit              src_calm;          // no gaps between source words while set
    bit              sink_calm;         // no stalls on the result side while set
    int unsigned     cycle_count;

    circular_queue_with_traverse_top #(
        .DEPTH(QDEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                     board.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one operation word, wait for the handshake, then update the mirror.
    // s_tvalid stays high into the next call, so back-to-back words need no gap.
    task automatic send_op(input logic [1:0] kind, input logic [DATA_W-1:0] value);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_op(kind, value);
    endtask

    // Mostly random data, with the sign and all-ones/all-zeros corners mixed in.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mode 0 fills, mode 1 drains, mode 2 keeps the level roughly steady.
    // Swinging between them walks the pointers around the ring and hits both
    // full and empty many times over.
    function automatic logic [1:0] pick_kind(int unsigned mode);
        int unsigned r;
        int unsigned ins_pct;
        r = $urandom_range(0, 99);
        case (mode)
            0:       ins_pct = 65;
            1:       ins_pct = 15;
            default: ins_pct = 40;
        endcase
        if (r < 4)            return KIND_UNUSED;
        if (r < 4 + 14)       return KIND_TRAVERSE;
        if (r < 18 + ins_pct) return KIND_INSERT;
        return KIND_DELETE;
    endfunction

    // Result side: random stall before each word, with stall-free stretches.
    initial begin : result_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken % 48 == 0)
                sink_calm = ($urandom_range(0, 2) == 0);
            taken++;
            hold = sink_calm ? 0 : $urandom_range(0, 16);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
            board.check_word(m_tuser, m_tdata, m_tlast);
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned mode;
        logic [1:0]  kind;
        board = new();
        mode  = 2;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty corner cases, a dropped code, a fill to full with
        // extreme values, a rejected insert, a full traverse, one delete, then a traverse.
        src_calm = 1'b0;
        send_op(KIND_TRAVERSE, pick_value());
        send_op(KIND_DELETE, pick_value());
        send_op(KIND_UNUSED, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 32'h8000_0000);
        send_op(KIND_INSERT, 32'h7FFF_FFFF);
        send_op(KIND_INSERT, 32'h0000_0000);
        send_op(KIND_INSERT, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 32'hAAAA_AAAA);
        send_op(KIND_INSERT, 32'h5555_5555);
        src_calm = 1'b1;
        for (int i = 0; i < QDEPTH - 6; i++)
            send_op(KIND_INSERT, $urandom());
        send_op(KIND_INSERT, 32'h1234_5678);       // queue full: rejected
        send_op(KIND_TRAVERSE, $urandom());        // sixteen words, last on the final
        send_op(KIND_DELETE, $urandom());
        send_op(KIND_TRAVERSE, $urandom());        // now starts one slot in

        // Random: dropped codes do not count toward the total.
        sent = 0;
        while (sent < RANDOM_OPS) begin
            if (sent % 30 == 0) begin
                mode     = $urandom_range(0, 2);
                src_calm = ($urandom_range(0, 3) == 0);
            end
            kind = pick_kind(mode);
            send_op(kind, pick_value());
            if (kind != KIND_UNUSED)
                sent++;
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray word.
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Sent %0d inserts (%0d full), %0d deletes (%0d empty), %0d traverses, %0d unused.",
                 board.n_insert, board.n_full, board.n_delete, board.n_empty,
                 board.n_traverse, board.n_dropped);
        $display("Checked %0d result words in %0d cycles, %0d mismatches.",
                 board.words_checked, cycle_count, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/cqt_pkg.sv
rtl/cqt_front.sv
rtl/cqt_back.sv
rtl/circular_queue_with_traverse_top.sv
verif/testbench.sv
